// ===== design/jfdm_pkg.sv =====
// Shared types and constants of the joystick frame drive mixer.
`timescale 1ns / 1ps

package jfdm_pkg;

   localparam int FRAME_MAX   = 250;
   localparam int PAYLOAD_LEN = 18;
   localparam int HDR_BYTES   = 4;
   localparam int AXIS_BYTES  = 6;
   localparam int MIN_FRAME   = HDR_BYTES + PAYLOAD_LEN + 1;

   localparam logic [7:0] START_BYTE = 8'h7E;
   localparam logic [7:0] STOP_BYTE  = 8'h81;

   localparam logic [12:0] AXIS_SPAN  = 13'd6000;
   localparam logic [6:0]  ANGLE_SPAN = 7'd120;

   // Exact floor division by 1023 for dividends below 2**28.
   localparam int          RECIP_SHIFT = 38;
   localparam logic [28:0] RECIP_1023  = 29'(((64'd1 << RECIP_SHIFT) + 64'd1022) / 64'd1023);

   localparam logic signed [18:0] AXIS_OFFSET = 19'sd3000;
   localparam logic signed [12:0] ANGLE_BASE  = 13'sd150;
   localparam logic signed [12:0] ANGLE_MAX   = 13'sd180;

   localparam logic [11:0] DEAD_ZONE_RESET = 12'd200;
   localparam logic [14:0] MAX_SPEED_RESET = 15'd3000;
   localparam logic [7:0]  ANGLE_RESET     = 8'd90;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_START  = 2'd1,
      STATUS_BAD_STOP   = 2'd2,
      STATUS_BAD_LENGTH = 2'd3
   } status_type;

   typedef enum logic {
      CSR_DEAD_ZONE = 1'b0,
      CSR_MAX_SPEED = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
      logic [7:0]         servo_angle;
   } rsp_type;

   typedef struct packed {
      status_type         status;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
   } frame_type;

endpackage

// ===== design/joystick_frame_drive_mixer.sv =====
// Top level of the joystick frame drive mixer: parser, frame queue, mixer and result queue.
//
//   channel  ports                           beat
//   req      req_push, req_full, req_data    one frame byte with its end flag
//   rsp      rsp_empty, rsp_pop, rsp_data    status and held drive values per frame
//   csr      csr_wr_en, csr_addr, csr_wdata  dead zone or speed limit write
//
// One byte beat is taken every cycle while the frame queue has room.
// A frame's result reaches the result queue through the frame queue and the mixer stages;
// the three-stage mixer issues one frame per cycle, paced by free result slots.
// Reset is synchronous and restores the held values and register defaults.
// A stalled result side fills the result queue, then the frame queue, then raises req_full.
`timescale 1ns / 1ps

module joystick_frame_drive_mixer #(
   parameter int MID_DEPTH = 4,
   parameter int RSP_DEPTH = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  jfdm_pkg::req_type       req_data,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output jfdm_pkg::rsp_type       rsp_data,
   input  logic                    csr_wr_en,
   input  jfdm_pkg::csr_index_type csr_addr,
   input  logic [14:0]             csr_wdata
);

   localparam int FRAME_W = $bits(jfdm_pkg::frame_type);
   localparam int RSP_W   = $bits(jfdm_pkg::rsp_type);

   logic                          req_accept;
   logic                          frame_push;
   jfdm_pkg::frame_type           frame_wr;
   logic [FRAME_W-1:0]            frame_rd_bits;
   logic                          mid_full;
   logic                          mid_empty;
   logic                          mid_pop;
   logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
   logic                          rsp_push;
   jfdm_pkg::rsp_type             rsp_wr;
   logic [RSP_W-1:0]              rsp_rd_bits;
   logic                          rsp_full;
   logic [$clog2(RSP_DEPTH+1)-1:0] rsp_count;
   logic [11:0]                   dead_zone_ff, dead_zone_in;
   logic [14:0]                   max_speed_ff, max_speed_in;

   assign req_full   = mid_full;
   assign req_accept = req_push && !mid_full;

   always_comb begin
      dead_zone_in = dead_zone_ff;
      max_speed_in = max_speed_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            jfdm_pkg::CSR_DEAD_ZONE: dead_zone_in = csr_wdata[11:0];
            jfdm_pkg::CSR_MAX_SPEED: max_speed_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= jfdm_pkg::DEAD_ZONE_RESET;
         max_speed_ff <= jfdm_pkg::MAX_SPEED_RESET;
      end else begin
         dead_zone_ff <= dead_zone_in;
         max_speed_ff <= max_speed_in;
      end
   end

   jfdm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .frame_push (frame_push),
      .frame_out  (frame_wr)
   );

   jfdm_fifo #(
      .WIDTH (FRAME_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (frame_push),
      .wr_data (frame_wr),
      .full    (mid_full),
      .pop     (mid_pop),
      .rd_data (frame_rd_bits),
      .empty   (mid_empty),
      .count   (mid_count)
   );

   jfdm_back #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_in    (jfdm_pkg::frame_type'(frame_rd_bits)),
      .frame_empty (mid_empty || (mid_count == '0)),
      .frame_pop   (mid_pop),
      .rsp_count   (rsp_count),
      .dead_zone   (dead_zone_ff),
      .max_speed   (max_speed_ff),
      .rsp_push    (rsp_push),
      .rsp_out     (rsp_wr)
   );

   jfdm_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push && !rsp_full),
      .wr_data (rsp_wr),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_rd_bits),
      .empty   (rsp_empty),
      .count   (rsp_count)
   );

   assign rsp_data = jfdm_pkg::rsp_type'(rsp_rd_bits);

endmodule

// ===== design/jfdm_fifo.sv =====
// Small first-in first-out queue of fixed-width entries.
`timescale 1ns / 1ps

module jfdm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wr_data,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== design/jfdm_front.sv =====
// Frame parser: tracks the byte position, checks the frame and emits one record per frame.
`timescale 1ns / 1ps

module jfdm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_accept,
   input  jfdm_pkg::req_type   req_data,
   output logic                frame_push,
   output jfdm_pkg::frame_type frame_out
);

   logic [7:0] byte_index_ff, byte_index_in;
   logic       start_ok_ff, start_ok_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] axis_ff [jfdm_pkg::AXIS_BYTES];
   logic [7:0] axis_off;
   logic       axis_wr;
   logic [8:0] byte_count;
   logic       length_bad;

   assign axis_off   = byte_index_ff - 8'(jfdm_pkg::HDR_BYTES);
   assign axis_wr    = req_accept
                    && (byte_index_ff >= 8'(jfdm_pkg::HDR_BYTES))
                    && (byte_index_ff < 8'(jfdm_pkg::HDR_BYTES + jfdm_pkg::AXIS_BYTES));
   assign byte_count = {1'b0, byte_index_ff} + 9'd1;

   always_comb begin
      byte_index_in = byte_index_ff;
      start_ok_in   = start_ok_ff;
      length_in     = length_ff;
      if (req_accept) begin
         if (byte_index_ff == 8'd0) begin
            start_ok_in = (req_data.data_byte == jfdm_pkg::START_BYTE);
            length_in   = 8'd0;
         end else if (byte_index_ff == 8'd3) begin
            length_in = req_data.data_byte;
         end
         if (req_data.frame_end) begin
            byte_index_in = 8'd0;
         end else if (byte_index_ff != 8'hFF) begin
            byte_index_in = byte_index_ff + 8'd1;
         end
      end
   end

   // Checks use the header values as updated by the final beat itself.
   assign length_bad = (length_in != 8'(jfdm_pkg::PAYLOAD_LEN))
                    || (byte_count < 9'(jfdm_pkg::MIN_FRAME))
                    || (byte_count > 9'(jfdm_pkg::FRAME_MAX));

   always_comb begin
      frame_out.axis_x = {axis_ff[1], axis_ff[0]};
      frame_out.axis_y = {axis_ff[3], axis_ff[2]};
      frame_out.axis_z = {axis_ff[5], axis_ff[4]};
      if (!start_ok_in) begin
         frame_out.status = jfdm_pkg::STATUS_BAD_START;
      end else if (req_data.data_byte != jfdm_pkg::STOP_BYTE) begin
         frame_out.status = jfdm_pkg::STATUS_BAD_STOP;
      end else if (length_bad) begin
         frame_out.status = jfdm_pkg::STATUS_BAD_LENGTH;
      end else begin
         frame_out.status = jfdm_pkg::STATUS_OK;
      end
   end

   assign frame_push = req_accept && req_data.frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= 8'd0;
         start_ok_ff   <= 1'b0;
         length_ff     <= 8'd0;
      end else begin
         byte_index_ff <= byte_index_in;
         start_ok_ff   <= start_ok_in;
         length_ff     <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (axis_wr) begin
         axis_ff[axis_off[2:0]] <= req_data.data_byte;
      end
   end

endmodule

// ===== design/jfdm_back.sv =====
// Drive mixer pipeline: axis scaling, dead zone, mixing, clamping and held outputs.
`timescale 1ns / 1ps

module jfdm_back #(
   parameter int RSP_DEPTH = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  jfdm_pkg::frame_type            frame_in,
   input  logic                           frame_empty,
   output logic                           frame_pop,
   input  logic [$clog2(RSP_DEPTH+1)-1:0] rsp_count,
   input  logic [11:0]                    dead_zone,
   input  logic [14:0]                    max_speed,
   output logic                           rsp_push,
   output jfdm_pkg::rsp_type              rsp_out
);

   localparam int CNT_W = $clog2(RSP_DEPTH + 1);
   localparam int RS    = jfdm_pkg::RECIP_SHIFT;

   // Stage 1: magnitudes times the axis spans.
   logic [15:0] x_mag, y_mag, z_mag;
   logic [27:0] prod_x_in, prod_y_in;
   logic [21:0] prod_z_in;
   logic [1:0]  inflight;
   logic        s1_valid_ff;
   logic        s2_valid_ff;
   logic        s3_valid_ff;
   jfdm_pkg::status_type s1_status_ff, s2_status_ff, s3_status_ff;
   logic [2:0]  s1_neg_ff, s2_neg_ff;
   logic [27:0] s1_prod_x_ff, s1_prod_y_ff;
   logic [21:0] s1_prod_z_ff;

   // Stage 2: division by 1023 through the reciprocal.
   logic [56:0] wide_x, wide_y;
   logic [50:0] wide_z;
   logic [17:0] s2_q_x_ff, s2_q_y_ff;
   logic [11:0] s2_q_z_ff;

   // Stage 3: signed axis values and their magnitudes.
   logic signed [18:0] sx, sy, a_in, b_in;
   logic signed [12:0] sz, ang_in;
   logic signed [18:0] s3_a_ff, s3_b_ff;
   logic [17:0]        s3_abs_a_ff, s3_abs_b_ff;
   logic signed [12:0] s3_ang_ff;

   // Final step: mixing and clamping.
   logic [17:0]        dz_ext;
   logic signed [18:0] lim, l_raw, r_raw, l_clip, r_clip;
   logic [7:0]         ang_clip;
   logic               good;
   logic signed [15:0] held_left_ff, held_left_in;
   logic signed [15:0] held_right_ff, held_right_in;
   logic [7:0]         held_angle_ff, held_angle_in;

   assign inflight  = {1'b0, s1_valid_ff} + {1'b0, s2_valid_ff} + {1'b0, s3_valid_ff};
   assign frame_pop = !frame_empty
                   && (({1'b0, rsp_count} + (CNT_W + 1)'(inflight)) < (CNT_W + 1)'(RSP_DEPTH));

   always_comb begin
      x_mag     = frame_in.axis_x[15] ? 16'(-frame_in.axis_x) : frame_in.axis_x;
      y_mag     = frame_in.axis_y[15] ? 16'(-frame_in.axis_y) : frame_in.axis_y;
      z_mag     = frame_in.axis_z[15] ? 16'(-frame_in.axis_z) : frame_in.axis_z;
      prod_x_in = 28'({12'd0, x_mag} * {15'd0, jfdm_pkg::AXIS_SPAN});
      prod_y_in = 28'({12'd0, y_mag} * {15'd0, jfdm_pkg::AXIS_SPAN});
      prod_z_in = 22'({6'd0, z_mag} * {15'd0, jfdm_pkg::ANGLE_SPAN});
   end

   always_comb begin
      wide_x = {29'd0, s1_prod_x_ff} * {28'd0, jfdm_pkg::RECIP_1023};
      wide_y = {29'd0, s1_prod_y_ff} * {28'd0, jfdm_pkg::RECIP_1023};
      wide_z = {29'd0, s1_prod_z_ff} * {22'd0, jfdm_pkg::RECIP_1023};
   end

   always_comb begin
      sx     = $signed({1'b0, s2_q_x_ff});
      sy     = $signed({1'b0, s2_q_y_ff});
      sz     = $signed({1'b0, s2_q_z_ff});
      a_in   = (s2_neg_ff[0] ? -sx : sx) - jfdm_pkg::AXIS_OFFSET;
      b_in   = (s2_neg_ff[1] ? -sy : sy) - jfdm_pkg::AXIS_OFFSET;
      ang_in = s2_neg_ff[2] ? (jfdm_pkg::ANGLE_BASE + sz) : (jfdm_pkg::ANGLE_BASE - sz);
   end

   always_comb begin
      dz_ext = {6'd0, dead_zone};
      lim    = $signed({4'd0, max_speed});
      if ((s3_abs_a_ff < dz_ext) && (s3_abs_b_ff < dz_ext)) begin
         l_raw = '0;
         r_raw = '0;
      end else if (s3_abs_a_ff > s3_abs_b_ff) begin
         l_raw = -s3_a_ff;
         r_raw = -s3_a_ff;
      end else begin
         l_raw = -s3_b_ff;
         r_raw = s3_b_ff;
      end
      if (l_raw > lim) begin
         l_clip = lim;
      end else if (l_raw < -lim) begin
         l_clip = -lim;
      end else begin
         l_clip = l_raw;
      end
      if (r_raw > lim) begin
         r_clip = lim;
      end else if (r_raw < -lim) begin
         r_clip = -lim;
      end else begin
         r_clip = r_raw;
      end
      if (s3_ang_ff < 13'sd0) begin
         ang_clip = 8'd0;
      end else if (s3_ang_ff > jfdm_pkg::ANGLE_MAX) begin
         ang_clip = 8'(jfdm_pkg::ANGLE_MAX);
      end else begin
         ang_clip = s3_ang_ff[7:0];
      end
   end

   assign good = (s3_status_ff == jfdm_pkg::STATUS_OK);

   always_comb begin
      held_left_in  = held_left_ff;
      held_right_in = held_right_ff;
      held_angle_in = held_angle_ff;
      if (s3_valid_ff && good) begin
         held_left_in  = l_clip[15:0];
         held_right_in = r_clip[15:0];
         held_angle_in = ang_clip;
      end
   end

   assign rsp_push            = s3_valid_ff;
   assign rsp_out.status      = s3_status_ff;
   assign rsp_out.left_speed  = held_left_in;
   assign rsp_out.right_speed = held_right_in;
   assign rsp_out.servo_angle = held_angle_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         held_left_ff  <= '0;
         held_right_ff <= '0;
         held_angle_ff <= jfdm_pkg::ANGLE_RESET;
      end else begin
         s1_valid_ff   <= frame_pop;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         held_left_ff  <= held_left_in;
         held_right_ff <= held_right_in;
         held_angle_ff <= held_angle_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_status_ff <= frame_in.status;
      s1_neg_ff    <= {frame_in.axis_z[15], frame_in.axis_y[15], frame_in.axis_x[15]};
      s1_prod_x_ff <= prod_x_in;
      s1_prod_y_ff <= prod_y_in;
      s1_prod_z_ff <= prod_z_in;
      s2_status_ff <= s1_status_ff;
      s2_neg_ff    <= s1_neg_ff;
      s2_q_x_ff    <= wide_x[RS+17:RS];
      s2_q_y_ff    <= wide_y[RS+17:RS];
      s2_q_z_ff    <= wide_z[RS+11:RS];
      s3_status_ff <= s2_status_ff;
      s3_a_ff      <= a_in;
      s3_b_ff      <= b_in;
      s3_abs_a_ff  <= a_in[18] ? 18'(-a_in) : a_in[17:0];
      s3_abs_b_ff  <= b_in[18] ? 18'(-b_in) : b_in[17:0];
      s3_ang_ff    <= ang_in;
   end

endmodule
